// ===== rtl/core/minhpq_pkg.sv =====
// types and codes shared by the keyed min-heap priority queue
package minhpq_pkg;

    localparam int KEY_W = 20;
    localparam int PAY_W = 20;
    localparam int OCC_W = 11;

    typedef enum logic
    {
        KIND_INSERT = 1'b0,
        KIND_POP    = 1'b1
    } kind_t;

    typedef enum logic [1:0]
    {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef struct packed
    {
        kind_t              kind;
        logic [KEY_W-1:0]   key;
        logic [PAY_W-1:0]   payload;
    } cmd_t;

    typedef struct packed
    {
        status_t            status;
        logic [KEY_W-1:0]   out_key;
        logic [PAY_W-1:0]   out_payload;
        logic [OCC_W-1:0]   occupancy;
    } rsp_t;

    typedef struct packed
    {
        logic [KEY_W-1:0]   key;
        logic [PAY_W-1:0]   payload;
    } entry_t;

endpackage

// ===== rtl/core/min_heap_keyed_priority_queue_unit.sv =====
// keyed binary min-heap priority queue with one entry memory
//
// usage: present a command word on cmd and raise start while busy is low; the
// word is taken at that clock edge. kind insert pushes (key, payload), kind pop
// removes the entry with the smallest key. busy stays high until the result.
// every command gives exactly one result word on rsp, shown for one cycle with
// done high; the receiver has no way to hold it off, so it must take it then.
// status: done, insert refused because full, pop refused because empty.
// occupancy is the entry count after the command.
// refused commands and an insert into an empty heap answer from idle, a pop
// that leaves at most one entry from the pop state. other inserts climb in
// the up state; other pops take the root and last entry in the pop state,
// then descend in the down state, and a sift that ends at the root or a leaf
// writes in the fin state. the sift loop does one memory read and one
// compare / write-back per level through the single-port-write entry ram.
// busy drops in the cycle that shows done, so a new command can be taken at
// the edge that ends it; commands answered from idle never raise busy.
// reset clears the entry count and the control state; the entry memory is
// not cleared, since only slots up to the count are ever read.
module min_heap_keyed_priority_queue_unit
    import minhpq_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  cmd_t    cmd,
    output logic    busy,
    output logic    done,
    output rsp_t    rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    typedef enum logic [4:0]
    {
        ST_IDLE = 5'b00001,
        ST_UP   = 5'b00010,
        ST_POP  = 5'b00100,
        ST_DN   = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  slot_reg, slot_next;
    entry_t         move_reg, move_next;
    rsp_t           rsp_reg, rsp_next;
    logic           done_reg, done_next;

    // entry memory, slot s lives at address s - 1
    entry_t         mem [DEPTH];
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    entry_t         wr_data;
    logic [AW-1:0]  rd_addr_a, rd_addr_b;
    entry_t         rd_a_q, rd_b_q;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_q <= mem[rd_addr_a];
        rd_b_q <= mem[rd_addr_b];
    end

    logic [CW-1:0]  count_inc, count_dec;
    logic [CW:0]    n_w;
    logic           use_right;
    logic [CW-1:0]  pick_slot;
    entry_t         pick_entry;
    logic [CW-1:0]  desc_slot;
    logic [CW:0]    left_w, right_w;
    logic           has_left, has_right;
    logic [AW-1:0]  left_addr, right_addr;
    logic [CW-1:0]  parent_slot;

    always_comb
    begin
        count_inc   = count_reg + CW'(1);
        count_dec   = count_reg - CW'(1);
        n_w         = {1'b0, count_reg};
        // equal child keys go right
        use_right   = ({slot_reg, 1'b1} <= n_w) && !(rd_a_q.key < rd_b_q.key);
        pick_slot   = CW'({slot_reg, use_right});
        pick_entry  = use_right ? rd_b_q : rd_a_q;
        desc_slot   = (state_reg == ST_POP) ? CW'(1) : pick_slot;
        left_w      = {desc_slot, 1'b0};
        right_w     = {desc_slot, 1'b1};
        has_left    = left_w <= n_w;
        has_right   = right_w <= n_w;
        left_addr   = AW'(left_w - (CW+1)'(1));
        right_addr  = has_right ? AW'(right_w - (CW+1)'(1)) : left_addr;
        parent_slot = slot_reg >> 1;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        slot_next  = slot_reg;
        move_next  = move_reg;
        rsp_next   = rsp_reg;
        done_next  = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = move_reg;
        rd_addr_a  = '0;
        rd_addr_b  = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    rsp_next.status      = STAT_DONE;
                    rsp_next.out_key     = '0;
                    rsp_next.out_payload = '0;
                    rsp_next.occupancy   = OCC_W'(count_reg);
                    if (cmd.kind == KIND_INSERT)
                    begin
                        if (count_reg == CW'(DEPTH))
                        begin
                            rsp_next.status = STAT_FULL;
                            done_next       = 1'b1;
                        end
                        else
                        begin
                            count_next         = count_inc;
                            rsp_next.occupancy = OCC_W'(count_inc);
                            move_next          = '{key: cmd.key, payload: cmd.payload};
                            slot_next          = count_inc;
                            if (count_reg == '0)
                            begin
                                wr_en     = 1'b1;
                                wr_addr   = '0;
                                wr_data   = '{key: cmd.key, payload: cmd.payload};
                                done_next = 1'b1;
                            end
                            else
                            begin
                                rd_addr_a  = AW'((count_inc >> 1) - CW'(1));
                                state_next = ST_UP;
                            end
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            rsp_next.status = STAT_EMPTY;
                            done_next       = 1'b1;
                        end
                        else
                        begin
                            count_next         = count_dec;
                            rsp_next.occupancy = OCC_W'(count_dec);
                            rd_addr_a          = '0;
                            rd_addr_b          = AW'(count_dec);
                            state_next         = ST_POP;
                        end
                    end
                end
            end

            ST_UP:
            begin
                // hole climbs while the parent key is strictly greater
                if (rd_a_q.key > move_reg.key)
                begin
                    wr_en     = 1'b1;
                    wr_addr   = AW'(slot_reg - CW'(1));
                    wr_data   = rd_a_q;
                    slot_next = parent_slot;
                    if (parent_slot == CW'(1))
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        rd_addr_a = AW'((parent_slot >> 1) - CW'(1));
                    end
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = AW'(slot_reg - CW'(1));
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_POP:
            begin
                rsp_next.out_key     = rd_a_q.key;
                rsp_next.out_payload = rd_a_q.payload;
                move_next            = rd_b_q;
                slot_next            = CW'(1);
                if (count_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (!has_left)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    wr_data    = rd_b_q;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_addr_a  = left_addr;
                    rd_addr_b  = right_addr;
                    state_next = ST_DN;
                end
            end

            ST_DN:
            begin
                if (pick_entry.key < move_reg.key)
                begin
                    wr_en     = 1'b1;
                    wr_addr   = AW'(slot_reg - CW'(1));
                    wr_data   = pick_entry;
                    slot_next = pick_slot;
                    if (!has_left)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        rd_addr_a = left_addr;
                        rd_addr_b = right_addr;
                    end
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = AW'(slot_reg - CW'(1));
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_FIN:
            begin
                wr_en      = 1'b1;
                wr_addr    = AW'(slot_reg - CW'(1));
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        move_reg <= move_next;
        rsp_reg  <= rsp_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // checks

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(start) && !$past(busy)) || $past(busy))
        else $error("result word without a command");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> ({1'b0, $past(wr_addr)} < (AW+1)'(count_reg)))
        else $error("write outside held entries");

    a_descend_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DN) |-> (slot_reg <= count_reg))
        else $error("sift down slot past the last entry");

endmodule

// ===== tb/minhpq_checker.sv =====
// checker for the keyed min-heap queue: tracks commands, predicts and compares result words
module minhpq_checker
    import minhpq_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    busy,
    input  cmd_t    cmd,
    input  logic    done,
    input  rsp_t    rsp,
    output int      mismatches,
    output int      waiting
);

    timeunit 1ns;
    timeprecision 1ps;

    entry_t      slots [1:DEPTH];
    int unsigned live;
    rsp_t        owed_rsps [$];

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s mismatch, got %h want %h", $realtime, field, got, want);
        mismatches++;
    endtask

    function automatic void swap_slots(int unsigned a, int unsigned b);
        entry_t t;
        t = slots[a];
        slots[a] = slots[b];
        slots[b] = t;
    endfunction

    // applies one command to the shadow heap and returns the word it should give
    function automatic rsp_t apply_heap_cmd(cmd_t c);
        rsp_t        r;
        int unsigned s;
        int unsigned left;
        int unsigned pick;
        r = '0;
        r.status = STAT_DONE;
        if (c.kind == KIND_INSERT)
        begin
            if (live >= DEPTH)
                r.status = STAT_FULL;
            else
            begin
                live++;
                slots[live].key = c.key;
                slots[live].payload = c.payload;
                s = live;
                // stop at a parent with an equal key
                while (s > 1 && slots[s / 2].key > slots[s].key)
                begin
                    swap_slots(s / 2, s);
                    s = s / 2;
                end
            end
        end
        else
        begin
            if (live == 0)
                r.status = STAT_EMPTY;
            else
            begin
                r.out_key = slots[1].key;
                r.out_payload = slots[1].payload;
                slots[1] = slots[live];
                live--;
                s = 1;
                while (2 * s <= live)
                begin
                    left = 2 * s;
                    pick = left;
                    // equal children: go right
                    if (left + 1 <= live && !(slots[left].key < slots[left + 1].key))
                        pick = left + 1;
                    if (slots[pick].key < slots[s].key)
                    begin
                        swap_slots(pick, s);
                        s = pick;
                    end
                    else
                        break;
                end
            end
        end
        r.occupancy = live[OCC_W-1:0];
        return r;
    endfunction

    initial
    begin
        mismatches = 0;
        waiting = 0;
        live = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            live = 0;
            owed_rsps.delete();
        end
        else
        begin
            // a result for an earlier word may land on the edge that takes the next one
            if (done)
            begin
                if (owed_rsps.size() == 0)
                    report_mismatch("unexpected word", 32'(rsp), 32'd0);
                else
                begin
                    want = owed_rsps.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", 32'(rsp.status), 32'(want.status));
                    if (rsp.out_key !== want.out_key)
                        report_mismatch("out_key", 32'(rsp.out_key), 32'(want.out_key));
                    if (rsp.out_payload !== want.out_payload)
                        report_mismatch("out_payload", 32'(rsp.out_payload),
                                        32'(want.out_payload));
                    if (rsp.occupancy !== want.occupancy)
                        report_mismatch("occupancy", 32'(rsp.occupancy), 32'(want.occupancy));
                end
            end
            if (start && !busy)
                owed_rsps.push_back(apply_heap_cmd(cmd));
        end
        waiting = owed_rsps.size();
    end

endmodule

// ===== tb/tb_min_heap_keyed_priority_queue_unit.sv =====
// testbench top for the keyed min-heap queue: stimulus, clock, reset and verdict
module tb_min_heap_keyed_priority_queue_unit
    import minhpq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP_DEPTH = 1024;
    localparam logic [KEY_W-1:0] KEY_MAX = '1;
    localparam logic [PAY_W-1:0] PAY_MAX = '1;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   start = 1'b0;
    cmd_t   cmd = '0;
    logic   busy;
    logic   done;
    rsp_t   rsp;
    int     mismatches;
    int     waiting;

    min_heap_keyed_priority_queue_unit #(.DEPTH(HEAP_DEPTH)) uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .rsp    (rsp)
    );

    minhpq_checker #(.DEPTH(HEAP_DEPTH)) checker_i
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .done       (done),
        .rsp        (rsp),
        .mismatches (mismatches),
        .waiting    (waiting)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic cmd_t build_cmd(kind_t k, logic [KEY_W-1:0] key,
                                       logic [PAY_W-1:0] payload);
        cmd_t c;
        c.kind = k;
        c.key = key;
        c.payload = payload;
        return c;
    endfunction

    // many small keys so that ties show up in both sift directions
    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: k = KEY_W'($urandom_range(0, 15));
            4:          k = $urandom_range(0, 1) ? KEY_MAX : '0;
            default:    k = KEY_W'($urandom);
        endcase
        return k;
    endfunction

    // holds start high with the word until the block takes it
    task automatic issue(cmd_t c);
        start <= 1'b1;
        cmd <= c;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(negedge clk);
        while (waiting != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic run_phase(int count, int insert_pct);
        int   left;
        int   burst;
        int   gap;
        kind_t k;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 16);
            while (burst > 0 && left > 0)
            begin
                k = ($urandom_range(1, 100) <= insert_pct) ? KIND_INSERT : KIND_POP;
                issue(build_cmd(k, pick_key(), PAY_W'($urandom)));
                burst--;
                left--;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // pop on empty, key and payload extremes, equal keys
        issue(build_cmd(KIND_POP, KEY_MAX, PAY_MAX));
        issue(build_cmd(KIND_INSERT, KEY_MAX, '0));
        issue(build_cmd(KIND_INSERT, '0, PAY_MAX));
        issue(build_cmd(KIND_INSERT, 20'd5, 20'd1));
        issue(build_cmd(KIND_INSERT, 20'd5, 20'd2));
        issue(build_cmd(KIND_INSERT, 20'd5, 20'd3));
        issue(build_cmd(KIND_INSERT, 20'd3, 20'haaaaa));
        issue(build_cmd(KIND_INSERT, 20'd3, 20'h55555));
        issue(build_cmd(KIND_INSERT, KEY_MAX, PAY_MAX));
        issue(build_cmd(KIND_INSERT, 20'd5, 20'd4));
        repeat (10) issue(build_cmd(KIND_POP, KEY_W'($urandom), PAY_W'($urandom)));
        drain_results();

        // random walk near empty, then fill past full, then drain part of it
        run_phase(300, 50);
        drain_results();
        run_phase(1150, 97);
        drain_results();
        run_phase(375, 3);
        drain_results();

        repeat (20) @(posedge clk);
        if (mismatches == 0 && waiting == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/minhpq_pkg.sv
rtl/core/min_heap_keyed_priority_queue_unit.sv
tb/minhpq_checker.sv
tb/tb_min_heap_keyed_priority_queue_unit.sv
